// ----- design/scs_pkg.sv -----
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and constants of the spline curvature speed sampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scs_pkg;

  typedef enum logic [2:0] {
    OP_MUL  = 3'b001,
    OP_DIV  = 3'b010,
    OP_SQRT = 3'b100
  } arith_op_t;

  typedef struct packed {
    logic        start;
    arith_op_t   op;
    logic [127:0] a;
    logic [127:0] b;
  } arith_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] res;
    logic [127:0] rem;
  } arith_rsp_t;

  typedef struct packed {
    logic        [31:0] duration;
    logic signed [31:0] cx0;
    logic signed [31:0] cx1;
    logic signed [31:0] cx2;
    logic signed [31:0] cx3;
    logic signed [31:0] cy0;
    logic signed [31:0] cy1;
    logic signed [31:0] cy2;
    logic signed [31:0] cy3;
  } seg_t;

  localparam logic [1:0] CFG_SAMPLES     = 2'd0;
  localparam logic [1:0] CFG_SPEED_LIMIT = 2'd1;
  localparam logic [1:0] CFG_GAIN        = 2'd2;

  localparam logic signed [63:0] LIM47  = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] NLIM47 = -64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] LIM31  = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] NLIM31 = -64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] NLIM32 = -64'sh0000_0000_8000_0000;
  localparam logic [63:0] KAPPA_FLOOR = 64'd42950;
  localparam logic [63:0] SPEED2_MIN  = 64'd4295;
  localparam logic [47:0] TIME_MAX    = 48'hFFFF_FFFF_FFFF;

endpackage

`default_nettype wire

// ----- design/scs_front.sv -----
// ----------------------------------------------------------------------------
// scs_front
// Segment intake: two-entry queue between the input channel and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scs_front
  import scs_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst_n,
  input  wire  logic in_valid,
  output logic       in_stall,
  input  seg_t       in_seg,
  output logic       q_valid,
  output seg_t       q_seg,
  input  wire  logic q_pop
);

  seg_t       mem_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_seg    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? !wr_r : wr_r;
    rd_nxt  = q_pop ? !rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= in_seg;
    end
  end

endmodule

`default_nettype wire

// ----- design/scs_arith.sv -----
// ----------------------------------------------------------------------------
// scs_arith
// Shared multi-cycle unit: 64x64 multiply (16-bit digits), 128/128 restoring
// divide with saturated 64-bit quotient, and 128-bit integer square root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scs_arith
  import scs_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst_n,
  input  arith_req_t req,
  output arith_rsp_t rsp
);

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL  = 4'b0010,
    A_DIV  = 4'b0100,
    A_SQRT = 4'b1000
  } astate_t;

  astate_t      st_r, st_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic [128:0] acc_r, acc_nxt;
  logic [127:0] opa_r, opa_nxt;
  logic [127:0] opb_r, opb_nxt;
  logic [63:0]  q_r, q_nxt;
  logic         sat_r, sat_nxt;
  logic         done_r, done_nxt;
  logic [127:0] res_r, res_nxt;
  logic [127:0] rem_r, rem_nxt;

  logic [79:0]  prod80;
  logic [128:0] sh;
  logic [128:0] trial;

  assign rsp.done = done_r;
  assign rsp.res  = res_r;
  assign rsp.rem  = rem_r;

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    opa_nxt  = opa_r;
    opb_nxt  = opb_r;
    q_nxt    = q_r;
    sat_nxt  = sat_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    rem_nxt  = rem_r;
    prod80   = opa_r[63:0] * opb_r[63:48];
    sh       = '0;
    trial    = '0;
    case (st_r)
      A_IDLE: begin
        if (req.start) begin
          acc_nxt = '0;
          opa_nxt = req.a;
          opb_nxt = req.b;
          q_nxt   = '0;
          sat_nxt = 1'b0;
          case (req.op)
            OP_MUL: begin
              cnt_nxt = 7'd3;
              opa_nxt = {64'b0, req.a[63:0]};
              opb_nxt = {64'b0, req.b[63:0]};
              st_nxt  = A_MUL;
            end
            OP_DIV: begin
              cnt_nxt = 7'd127;
              st_nxt  = A_DIV;
            end
            OP_SQRT: begin
              cnt_nxt = 7'd63;
              st_nxt  = A_SQRT;
            end
            default: st_nxt = A_IDLE;
          endcase
        end
      end
      A_MUL: begin
        acc_nxt = {acc_r[112:0], 16'b0} + {49'b0, prod80};
        opb_nxt = {opb_r[111:0], 16'b0};
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd0) begin
          res_nxt  = acc_nxt[127:0];
          done_nxt = 1'b1;
          st_nxt   = A_IDLE;
        end
      end
      A_DIV: begin
        sh      = {acc_r[127:0], opa_r[127]};
        opa_nxt = {opa_r[126:0], 1'b0};
        if (sh >= {1'b0, opb_r}) begin
          acc_nxt = sh - {1'b0, opb_r};
          if (cnt_r[6]) begin
            sat_nxt = 1'b1;
          end else begin
            q_nxt = {q_r[62:0], 1'b1};
          end
        end else begin
          acc_nxt = sh;
          if (!cnt_r[6]) begin
            q_nxt = {q_r[62:0], 1'b0};
          end
        end
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd0) begin
          res_nxt  = sat_r ? {64'b0, {64{1'b1}}} : {64'b0, q_nxt};
          rem_nxt  = acc_nxt[127:0];
          done_nxt = 1'b1;
          st_nxt   = A_IDLE;
        end
      end
      A_SQRT: begin
        sh      = {acc_r[126:0], opa_r[127:126]};
        trial   = {63'b0, q_r, 2'b01};
        opa_nxt = {opa_r[125:0], 2'b00};
        if (sh >= trial) begin
          acc_nxt = sh - trial;
          q_nxt   = {q_r[62:0], 1'b1};
        end else begin
          acc_nxt = sh;
          q_nxt   = {q_r[62:0], 1'b0};
        end
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd0) begin
          res_nxt  = {64'b0, q_nxt};
          done_nxt = 1'b1;
          st_nxt   = A_IDLE;
        end
      end
      default: st_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    opa_r <= opa_nxt;
    opb_r <= opb_nxt;
    q_r   <= q_nxt;
    sat_r <= sat_nxt;
    res_r <= res_nxt;
    rem_r <= rem_nxt;
  end

endmodule

`default_nettype wire

// ----- design/scs_back.sv -----
// ----------------------------------------------------------------------------
// scs_back
// Segment sequencer: curvature sweep, speed, point sampling and travel time;
// mul, div and sqrt issued to the shared unit; one-entry output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scs_back
  import scs_pkg::*;
#(
  parameter int CURVE_SAMPLES = 20
) (
  input  wire  logic        clk,
  input  wire  logic        rst_n,
  input  wire  logic        seg_valid,
  input  seg_t              seg,
  output logic              seg_pop,
  input  wire  logic [5:0]  n_pts,
  input  wire  logic [31:0] speed_limit,
  input  wire  logic [31:0] gain,
  output arith_req_t        req,
  input  arith_rsp_t        rsp,
  output logic              out_valid,
  input  wire  logic        out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [31:0]       out_speed,
  output logic [47:0]       out_elapsed_time,
  output logic              out_last_of_segment
);

  localparam int RC_W = $clog2(CURVE_SAMPLES + 1);
  localparam logic [RC_W-1:0] NC = RC_W'(CURVE_SAMPLES);

  typedef enum logic [20:0] {
    S_IDLE   = 21'h000001,
    S_WAIT   = 21'h000002,
    S_CDIV   = 21'h000004,
    S_PDIV   = 21'h000008,
    S_MAC    = 21'h000010,
    S_MACD   = 21'h000020,
    S_CROSS  = 21'h000040,
    S_CROSSD = 21'h000080,
    S_SQS    = 21'h000100,
    S_SR     = 21'h000200,
    S_SD     = 21'h000400,
    S_KD     = 21'h000800,
    S_KUPD   = 21'h001000,
    S_SPD    = 21'h002000,
    S_SPR    = 21'h004000,
    S_DIST   = 21'h008000,
    S_DX     = 21'h010000,
    S_DY     = 21'h020000,
    S_DS     = 21'h040000,
    S_DT     = 21'h080000,
    S_EMIT   = 21'h100000
  } state_t;

  function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic signed [63:0] clamp47(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > LIM47) r = LIM47;
    if (v < NLIM47) r = NLIM47;
    return r;
  endfunction

  function automatic logic signed [31:0] clamp31(input logic signed [63:0] v);
    logic signed [31:0] r;
    r = v[31:0];
    if (v > LIM31) r = LIM31[31:0];
    if (v < NLIM31) r = NLIM31[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    logic signed [31:0] r;
    r = v[31:0];
    if (v > LIM31) r = LIM31[31:0];
    if (v < NLIM32) r = NLIM32[31:0];
    return r;
  endfunction

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;
  seg_t   seg_r, seg_nxt;

  logic [31:0]     qc_r, qc_nxt, tc_r, tc_nxt;
  logic [RC_W-1:0] rcq_r, rcq_nxt, rca_r, rca_nxt, ci_r, ci_nxt;
  logic [31:0]     qp_r, qp_nxt, tp_r, tp_nxt;
  logic [5:0]      rpq_r, rpq_nxt, rpa_r, rpa_nxt, pi_r, pi_nxt;
  logic [3:0]      uop_r, uop_nxt;
  logic [1:0]      pstep_r, pstep_nxt;

  logic signed [63:0] acc_r, acc_nxt;
  logic signed [31:0] x1_r, x1_nxt, x2_r, x2_nxt, y1_r, y1_nxt, y2_r, y2_nxt;
  logic signed [31:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [63:0] p_r [4];
  logic signed [63:0] p_wr;
  logic               p_we;
  logic [63:0]  n_r, n_nxt, s_r, s_nxt, k_r, k_nxt, kmax_r, kmax_nxt;
  logic [31:0]  speed_r, speed_nxt;
  logic [65:0]  a_r, a_nxt;

  logic signed [31:0] prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic [47:0]  time_r, time_nxt;
  logic         have_r, have_nxt;

  logic               ov_r, ov_nxt;
  logic signed [31:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic [31:0]        os_r, os_nxt;
  logic [47:0]        ot_r, ot_nxt;
  logic               ol_r, ol_nxt;

  logic               axis_y;
  logic signed [63:0] c0, c1, c2, c3, src_v, add_v, m_s, sum_s, mac_v;
  logic [63:0]        src_mag, m_u;
  logic [31:0]        t_cur;
  logic signed [31:0] pa, pb;
  logic [31:0]        pa_m, pb_m;
  logic               p_neg;
  logic signed [63:0] n_c;
  logic [63:0]        n_mag, s_c, kf;
  logic signed [32:0] dx33, dy33;
  logic [32:0]        dx_m, dy_m;
  logic [66:0]        dsum;
  logic [50:0]        tsum;
  logic [RC_W:0]      rc_sum;
  logic [6:0]         rp_sum;

  assign out_valid           = ov_r;
  assign out_pos_x           = ox_r;
  assign out_pos_y           = oy_r;
  assign out_speed           = os_r;
  assign out_elapsed_time    = ot_r;
  assign out_last_of_segment = ol_r;

  always_comb begin
    axis_y = (uop_r == 4'd3) || (uop_r == 4'd4) || (uop_r == 4'd5) ||
             (uop_r == 4'd9) || (uop_r == 4'd10) || (uop_r == 4'd11);
    c0 = axis_y ? sx64(seg_r.cy0) : sx64(seg_r.cx0);
    c1 = axis_y ? sx64(seg_r.cy1) : sx64(seg_r.cx1);
    c2 = axis_y ? sx64(seg_r.cy2) : sx64(seg_r.cx2);
    c3 = axis_y ? sx64(seg_r.cy3) : sx64(seg_r.cx3);
    case (uop_r)
      4'd0, 4'd3: src_v = c3 + (c3 <<< 1);
      4'd2, 4'd5: src_v = (c3 <<< 2) + (c3 <<< 1);
      4'd6, 4'd9: src_v = c3;
      default:    src_v = acc_r;
    endcase
    case (uop_r)
      4'd0, 4'd2, 4'd3, 4'd5: add_v = c2 <<< 1;
      4'd1, 4'd4, 4'd7, 4'd10: add_v = c1;
      4'd6, 4'd9: add_v = c2;
      default:    add_v = c0;
    endcase
    t_cur   = (uop_r < 4'd6) ? tc_r : tp_r;
    src_mag = src_v[63] ? 64'(-src_v) : 64'(src_v);
    m_u     = (|rsp.res[127:63]) ? 64'(LIM47) : {17'b0, rsp.res[62:16]};
    m_s     = src_v[63] ? -signed'(m_u) : signed'(m_u);
    sum_s   = m_s + add_v;
    mac_v   = clamp47(sum_s);

    case (pstep_r)
      2'd0:    begin pa = x1_r; pb = y2_r; end
      2'd1:    begin pa = y1_r; pb = x2_r; end
      2'd2:    begin pa = x1_r; pb = x1_r; end
      default: begin pa = y1_r; pb = y1_r; end
    endcase
    pa_m  = pa[31] ? 32'(-pa) : 32'(pa);
    pb_m  = pb[31] ? 32'(-pb) : 32'(pb);
    p_neg = pa[31] ^ pb[31];

    n_c   = p_r[0] - p_r[1];
    n_mag = n_c[63] ? 64'(-n_c) : 64'(n_c);
    s_c   = 64'(p_r[2]) + 64'(p_r[3]);
    kf    = (kmax_r < KAPPA_FLOOR) ? KAPPA_FLOOR : kmax_r;

    dx33 = {px_r[31], px_r} - {prev_x_r[31], prev_x_r};
    dy33 = {py_r[31], py_r} - {prev_y_r[31], prev_y_r};
    dx_m = dx33[32] ? 33'(-dx33) : 33'(dx33);
    dy_m = dy33[32] ? 33'(-dy33) : 33'(dy33);
    dsum = {1'b0, a_r} + {1'b0, rsp.res[65:0]};
    tsum = {3'b0, time_r} + {1'b0, rsp.res[49:0]};

    rc_sum = {1'b0, rca_r} + {1'b0, rcq_r};
    rp_sum = {1'b0, rpa_r} + {1'b0, rpq_r};
  end

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    seg_nxt    = seg_r;
    qc_nxt     = qc_r;
    tc_nxt     = tc_r;
    rcq_nxt    = rcq_r;
    rca_nxt    = rca_r;
    ci_nxt     = ci_r;
    qp_nxt     = qp_r;
    tp_nxt     = tp_r;
    rpq_nxt    = rpq_r;
    rpa_nxt    = rpa_r;
    pi_nxt     = pi_r;
    uop_nxt    = uop_r;
    pstep_nxt  = pstep_r;
    acc_nxt    = acc_r;
    x1_nxt     = x1_r;
    x2_nxt     = x2_r;
    y1_nxt     = y1_r;
    y2_nxt     = y2_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    p_we       = 1'b0;
    p_wr       = '0;
    n_nxt      = n_r;
    s_nxt      = s_r;
    k_nxt      = k_r;
    kmax_nxt   = kmax_r;
    speed_nxt  = speed_r;
    a_nxt      = a_r;
    prev_x_nxt = prev_x_r;
    prev_y_nxt = prev_y_r;
    time_nxt   = time_r;
    have_nxt   = have_r;
    ov_nxt     = ov_r && out_stall;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    os_nxt     = os_r;
    ot_nxt     = ot_r;
    ol_nxt     = ol_r;
    seg_pop    = 1'b0;
    req.start  = 1'b0;
    req.op     = OP_MUL;
    req.a      = '0;
    req.b      = '0;

    case (state_r)
      S_IDLE: begin
        if (seg_valid) begin
          seg_pop   = 1'b1;
          seg_nxt   = seg;
          req.start = 1'b1;
          req.op    = OP_DIV;
          req.a     = {96'b0, seg.duration};
          req.b     = 128'(NC);
          ret_nxt   = S_CDIV;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (rsp.done) state_nxt = ret_r;
      end
      S_CDIV: begin
        qc_nxt    = rsp.res[31:0];
        rcq_nxt   = rsp.rem[RC_W-1:0];
        req.start = 1'b1;
        req.op    = OP_DIV;
        req.a     = {96'b0, seg_r.duration};
        req.b     = {122'b0, n_pts};
        ret_nxt   = S_PDIV;
        state_nxt = S_WAIT;
      end
      S_PDIV: begin
        qp_nxt    = rsp.res[31:0];
        rpq_nxt   = rsp.rem[5:0];
        tc_nxt    = '0;
        rca_nxt   = '0;
        ci_nxt    = '0;
        kmax_nxt  = '0;
        uop_nxt   = 4'd0;
        state_nxt = S_MAC;
      end
      S_MAC: begin
        req.start = 1'b1;
        req.op    = OP_MUL;
        req.a     = {64'b0, src_mag};
        req.b     = {96'b0, t_cur};
        ret_nxt   = S_MACD;
        state_nxt = S_WAIT;
      end
      S_MACD: begin
        uop_nxt   = uop_r + 4'd1;
        state_nxt = S_MAC;
        case (uop_r)
          4'd1:  x1_nxt = clamp31(mac_v);
          4'd2:  x2_nxt = clamp31(mac_v);
          4'd4:  y1_nxt = clamp31(mac_v);
          4'd5: begin
            y2_nxt    = clamp31(mac_v);
            pstep_nxt = 2'd0;
            state_nxt = S_CROSS;
          end
          4'd8:  px_nxt = clamp32(mac_v);
          4'd11: begin
            py_nxt    = clamp32(mac_v);
            state_nxt = S_DIST;
          end
          default: acc_nxt = mac_v;
        endcase
      end
      S_CROSS: begin
        req.start = 1'b1;
        req.op    = OP_MUL;
        req.a     = {96'b0, pa_m};
        req.b     = {96'b0, pb_m};
        ret_nxt   = S_CROSSD;
        state_nxt = S_WAIT;
      end
      S_CROSSD: begin
        p_we      = 1'b1;
        p_wr      = p_neg ? -signed'(rsp.res[63:0]) : signed'(rsp.res[63:0]);
        pstep_nxt = pstep_r + 2'd1;
        state_nxt = (pstep_r == 2'd3) ? S_SQS : S_CROSS;
      end
      S_SQS: begin
        n_nxt = n_mag;
        s_nxt = s_c;
        if (s_c < SPEED2_MIN) begin
          k_nxt     = KAPPA_FLOOR;
          state_nxt = S_KUPD;
        end else begin
          req.start = 1'b1;
          req.op    = OP_SQRT;
          req.a     = {64'b0, s_c};
          ret_nxt   = S_SR;
          state_nxt = S_WAIT;
        end
      end
      S_SR: begin
        req.start = 1'b1;
        req.op    = OP_MUL;
        req.a     = {64'b0, s_r};
        req.b     = {64'b0, rsp.res[63:0]};
        ret_nxt   = S_SD;
        state_nxt = S_WAIT;
      end
      S_SD: begin
        req.start = 1'b1;
        req.op    = OP_DIV;
        req.a     = {16'b0, n_r, 48'b0};
        req.b     = rsp.res;
        ret_nxt   = S_KD;
        state_nxt = S_WAIT;
      end
      S_KD: begin
        k_nxt     = rsp.res[63:0];
        state_nxt = S_KUPD;
      end
      S_KUPD: begin
        if (k_r > kmax_r) kmax_nxt = k_r;
        if (ci_r == NC) begin
          state_nxt = S_SPD;
        end else begin
          ci_nxt = ci_r + 1'b1;
          if (rc_sum >= {1'b0, NC}) begin
            rca_nxt = RC_W'(rc_sum - {1'b0, NC});
            tc_nxt  = tc_r + qc_r + 32'd1;
          end else begin
            rca_nxt = rc_sum[RC_W-1:0];
            tc_nxt  = tc_r + qc_r;
          end
          uop_nxt   = 4'd0;
          state_nxt = S_MAC;
        end
      end
      S_SPD: begin
        req.start = 1'b1;
        req.op    = OP_DIV;
        req.a     = {64'b0, gain, 32'b0};
        req.b     = {64'b0, kf};
        ret_nxt   = S_SPR;
        state_nxt = S_WAIT;
      end
      S_SPR: begin
        speed_nxt = (rsp.res[63:0] > {32'b0, speed_limit}) ? speed_limit : rsp.res[31:0];
        pi_nxt    = '0;
        tp_nxt    = '0;
        rpa_nxt   = '0;
        uop_nxt   = 4'd6;
        state_nxt = S_MAC;
      end
      S_DIST: begin
        if (have_r && (speed_r != 32'd0)) begin
          req.start = 1'b1;
          req.op    = OP_MUL;
          req.a     = {95'b0, dx_m};
          req.b     = {95'b0, dx_m};
          ret_nxt   = S_DX;
          state_nxt = S_WAIT;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_DX: begin
        a_nxt     = rsp.res[65:0];
        req.start = 1'b1;
        req.op    = OP_MUL;
        req.a     = {95'b0, dy_m};
        req.b     = {95'b0, dy_m};
        ret_nxt   = S_DY;
        state_nxt = S_WAIT;
      end
      S_DY: begin
        req.start = 1'b1;
        req.op    = OP_SQRT;
        req.a     = {61'b0, dsum};
        ret_nxt   = S_DS;
        state_nxt = S_WAIT;
      end
      S_DS: begin
        req.start = 1'b1;
        req.op    = OP_DIV;
        req.a     = {78'b0, rsp.res[33:0], 16'b0};
        req.b     = {96'b0, speed_r};
        ret_nxt   = S_DT;
        state_nxt = S_WAIT;
      end
      S_DT: begin
        time_nxt  = (tsum > {3'b0, TIME_MAX}) ? TIME_MAX : tsum[47:0];
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt     = 1'b1;
          ox_nxt     = px_r;
          oy_nxt     = py_r;
          os_nxt     = speed_r;
          ot_nxt     = time_r;
          ol_nxt     = (pi_r == n_pts);
          have_nxt   = 1'b1;
          prev_x_nxt = px_r;
          prev_y_nxt = py_r;
          if (pi_r == n_pts) begin
            state_nxt = S_IDLE;
          end else begin
            pi_nxt = pi_r + 6'd1;
            if (rp_sum >= {1'b0, n_pts}) begin
              rpa_nxt = 6'(rp_sum - {1'b0, n_pts});
              tp_nxt  = tp_r + qp_r + 32'd1;
            end else begin
              rpa_nxt = rp_sum[5:0];
              tp_nxt  = tp_r + qp_r;
            end
            uop_nxt   = 4'd6;
            state_nxt = S_MAC;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ret_r    <= S_IDLE;
      ov_r     <= 1'b0;
      have_r   <= 1'b0;
      prev_x_r <= '0;
      prev_y_r <= '0;
      time_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      ov_r     <= ov_nxt;
      have_r   <= have_nxt;
      prev_x_r <= prev_x_nxt;
      prev_y_r <= prev_y_nxt;
      time_r   <= time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seg_r   <= seg_nxt;
    qc_r    <= qc_nxt;
    tc_r    <= tc_nxt;
    rcq_r   <= rcq_nxt;
    rca_r   <= rca_nxt;
    ci_r    <= ci_nxt;
    qp_r    <= qp_nxt;
    tp_r    <= tp_nxt;
    rpq_r   <= rpq_nxt;
    rpa_r   <= rpa_nxt;
    pi_r    <= pi_nxt;
    uop_r   <= uop_nxt;
    pstep_r <= pstep_nxt;
    acc_r   <= acc_nxt;
    x1_r    <= x1_nxt;
    x2_r    <= x2_nxt;
    y1_r    <= y1_nxt;
    y2_r    <= y2_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    n_r     <= n_nxt;
    s_r     <= s_nxt;
    k_r     <= k_nxt;
    kmax_r  <= kmax_nxt;
    speed_r <= speed_nxt;
    a_r     <= a_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    os_r    <= os_nxt;
    ot_r    <= ot_nxt;
    ol_r    <= ol_nxt;
    if (p_we) begin
      p_r[pstep_r] <= p_wr;
    end
  end

endmodule

`default_nettype wire

// ----- design/spline_curvature_speed_sampler_unit.sv -----
// ----------------------------------------------------------------------------
// A segment takes (CURVE_SAMPLES+1) curvature samples, then emits its points;
// all multiply, divide and root work goes to the shared arithmetic unit
// (128-step divide, 64-step root, 4-step multiply). Segments run one at a time;
// a two-entry queue takes new segments meanwhile. Synchronous active-low reset
// clears the registers to defaults, the travel time and the previous point.
// ----------------------------------------------------------------------------
// spline_curvature_speed_sampler_unit
// Top level: configuration registers, intake queue, sequencer, shared unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spline_curvature_speed_sampler_unit
  import scs_pkg::*;
#(
  parameter int CURVE_SAMPLES = 20
) (
  input  wire  logic        clk,
  input  wire  logic        rst_n,
  input  wire  logic        cfg_we,
  input  wire  logic [1:0]  cfg_index,
  input  wire  logic [31:0] cfg_data,
  input  wire  logic        in_valid,
  output logic              in_stall,
  input  wire  logic [31:0] in_duration,
  input  wire  logic signed [31:0] in_coef_x0,
  input  wire  logic signed [31:0] in_coef_x1,
  input  wire  logic signed [31:0] in_coef_x2,
  input  wire  logic signed [31:0] in_coef_x3,
  input  wire  logic signed [31:0] in_coef_y0,
  input  wire  logic signed [31:0] in_coef_y1,
  input  wire  logic signed [31:0] in_coef_y2,
  input  wire  logic signed [31:0] in_coef_y3,
  output logic              out_valid,
  input  wire  logic        out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [31:0]       out_speed,
  output logic [47:0]       out_elapsed_time,
  output logic              out_last_of_segment
);

  logic [5:0]  spp_r, spp_nxt;
  logic [31:0] limit_r, limit_nxt;
  logic [31:0] gain_r, gain_nxt;
  logic [5:0]  n_pts;

  seg_t       in_seg, q_seg;
  logic       q_valid, q_pop;
  arith_req_t req;
  arith_rsp_t rsp;

  always_comb begin
    spp_nxt   = spp_r;
    limit_nxt = limit_r;
    gain_nxt  = gain_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SAMPLES:     spp_nxt   = cfg_data[5:0];
        CFG_SPEED_LIMIT: limit_nxt = cfg_data;
        CFG_GAIN:        gain_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spp_r   <= 6'd20;
      limit_r <= 32'd32768;
      gain_r  <= 32'd32768;
    end else begin
      spp_r   <= spp_nxt;
      limit_r <= limit_nxt;
      gain_r  <= gain_nxt;
    end
  end

  assign n_pts = (spp_r == 6'd0) ? 6'd1 : spp_r;

  assign in_seg = '{duration: in_duration,
                    cx0: in_coef_x0, cx1: in_coef_x1, cx2: in_coef_x2, cx3: in_coef_x3,
                    cy0: in_coef_y0, cy1: in_coef_y1, cy2: in_coef_y2, cy3: in_coef_y3};

  scs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_seg   (in_seg),
    .q_valid  (q_valid),
    .q_seg    (q_seg),
    .q_pop    (q_pop)
  );

  scs_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  scs_back #(
    .CURVE_SAMPLES (CURVE_SAMPLES)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .seg_valid           (q_valid),
    .seg                 (q_seg),
    .seg_pop             (q_pop),
    .n_pts               (n_pts),
    .speed_limit         (limit_r),
    .gain                (gain_r),
    .req                 (req),
    .rsp                 (rsp),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_pos_x           (out_pos_x),
    .out_pos_y           (out_pos_y),
    .out_speed           (out_speed),
    .out_elapsed_time    (out_elapsed_time),
    .out_last_of_segment (out_last_of_segment)
  );

endmodule

`default_nettype wire

// ----- design/scs_checker.sv -----
// ----------------------------------------------------------------------------
// scs_checker
// Port-level checks on the result channel of the sampler, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_pos_x,
  input wire logic [31:0] out_speed,
  input wire logic [47:0] out_elapsed_time,
  input wire logic        out_last_of_segment
);

  logic        acc;
  logic [47:0] last_time_r;
  logic [31:0] seg_speed_r;
  logic        mid_r;

  assign acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
      seg_speed_r <= '0;
      mid_r       <= 1'b0;
    end else if (acc) begin
      last_time_r <= out_elapsed_time;
      seg_speed_r <= out_speed;
      mid_r       <= !out_last_of_segment;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pos_x))
    else $error("result dropped or changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_time: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> out_elapsed_time >= last_time_r)
    else $error("elapsed time went backwards");

  a_speed: assert property (@(posedge clk) disable iff (!rst_n)
    acc && mid_r |-> out_speed == seg_speed_r)
    else $error("speed changed within a segment");

endmodule

bind spline_curvature_speed_sampler_unit scs_checker u_chk (.*);

`default_nettype wire

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// Spline curvature speed sampler testbench
// Feeds cubic spline segments through a valid/stall channel and checks every
// sampled point against an in-bench fixed-point predictor of the curvature
// limited speed, position and cumulative travel time. Configuration is
// rewritten between phases while the block is idle; both sides stall at
// random and the receiver holds off long enough for the intake to back up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import scs_pkg::*;

  localparam int       N_CURVE    = 20;
  localparam longint   CYCLE_CAP  = 20_000_000;
  localparam int       HOLD_SPAN  = 3000;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        speed;
    logic [47:0]        elapsed;
    logic               last;
  } point_t;

  typedef longint coef4_t [4];

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_SAMPLES;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_duration = '0;
  logic signed [31:0] in_coef_x0 = '0, in_coef_x1 = '0, in_coef_x2 = '0, in_coef_x3 = '0;
  logic signed [31:0] in_coef_y0 = '0, in_coef_y1 = '0, in_coef_y2 = '0, in_coef_y3 = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [31:0] out_pos_x, out_pos_y;
  logic [31:0] out_speed;
  logic [47:0] out_elapsed_time;
  logic        out_last_of_segment;

  spline_curvature_speed_sampler_unit #(.CURVE_SAMPLES(N_CURVE)) dut (.*);

  seg_t   pending_segs[$];
  point_t expected_points[$];

  // predictor state
  logic [5:0]  samples_reg = 6'd20;
  logic [31:0] limit_reg = 32'd32768;
  logic [31:0] gain_reg = 32'd32768;
  longint      last_x = 0, last_y = 0;
  logic [63:0] travel_time = '0;
  logic        point_seen = 1'b0;

  int     sender_idle_pct = 0;
  int     receiver_idle_pct = 0;
  int     hold_off_count = 0;
  int     hold_off_seen = 0;
  int     stall_left = 0;
  int     mismatches = 0;
  longint cycles = 0;
  logic   in_fire = 1'b0;

  initial forever #5 clk = ~clk;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [63:0] abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    logic [127:0] p;
    logic [63:0]  m;
    p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
    if (p[127:80] != '0) m = LIM47;
    else m = p[79:16];
    if (m > LIM47) m = LIM47;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint horner(longint acc, longint t, longint add);
    return clip(qmul(acc, t) + add, -longint'(LIM47), longint'(LIM47));
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] n);
    logic [63:0] r, c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= n) r = c;
    end
    return r;
  endfunction

  function automatic longint poly_at(coef4_t c, longint t);
    return clip(horner(horner(horner(c[3], t, c[2]), t, c[1]), t, c[0]),
                -longint'(LIM31) - 1, longint'(LIM31));
  endfunction

  function automatic logic [63:0] curvature_at(coef4_t cx, coef4_t cy, longint t);
    longint x1, x2, y1, y2;
    logic [63:0] n, s;
    logic [127:0] num, den, q;
    x1 = clip(horner(horner(3 * cx[3], t, 2 * cx[2]), t, cx[1]), -longint'(LIM31), LIM31);
    x2 = clip(horner(6 * cx[3], t, 2 * cx[2]), -longint'(LIM31), LIM31);
    y1 = clip(horner(horner(3 * cy[3], t, 2 * cy[2]), t, cy[1]), -longint'(LIM31), LIM31);
    y2 = clip(horner(6 * cy[3], t, 2 * cy[2]), -longint'(LIM31), LIM31);
    n = abs64(x1 * y2 - y1 * x2);
    s = x1 * x1 + y1 * y1;
    if (s < SPEED2_MIN) return KAPPA_FLOOR;
    num = {64'd0, n} << 48;
    den = {64'd0, s} * {64'd0, isqrt({64'd0, s})};
    q = num / den;
    return (q[127:64] != '0) ? '1 : q[63:0];
  endfunction

  task automatic predict_segment(seg_t sg);
    coef4_t cx, cy;
    logic [63:0] kmax, k, spd, n, t, ds, dt;
    logic [127:0] d2;
    longint x, y;
    point_t pt;
    cx = '{longint'(sg.cx0), longint'(sg.cx1), longint'(sg.cx2), longint'(sg.cx3)};
    cy = '{longint'(sg.cy0), longint'(sg.cy1), longint'(sg.cy2), longint'(sg.cy3)};
    kmax = '0;
    for (int i = 0; i <= N_CURVE; i++) begin
      t = (64'(i) * 64'(sg.duration)) / N_CURVE;
      k = curvature_at(cx, cy, longint'(t));
      if (k > kmax) kmax = k;
    end
    if (kmax < KAPPA_FLOOR) kmax = KAPPA_FLOOR;
    spd = {gain_reg, 32'd0} / kmax;
    if (spd > limit_reg) spd = limit_reg;
    n = (samples_reg == 0) ? 64'd1 : 64'(samples_reg);
    for (longint i = 0; i <= n; i++) begin
      t = (64'(i) * 64'(sg.duration)) / n;
      x = poly_at(cx, longint'(t));
      y = poly_at(cy, longint'(t));
      if (point_seen && spd != 0) begin
        d2 = {64'd0, abs64(x - last_x)} * {64'd0, abs64(x - last_x)}
           + {64'd0, abs64(y - last_y)} * {64'd0, abs64(y - last_y)};
        ds = isqrt(d2);
        dt = (ds << 16) / spd;
        travel_time = (dt > 64'(TIME_MAX) - travel_time) ? 64'(TIME_MAX) : travel_time + dt;
      end
      point_seen = 1'b1;
      last_x = x;
      last_y = y;
      pt.pos_x = x[31:0];
      pt.pos_y = y[31:0];
      pt.speed = spd[31:0];
      pt.elapsed = travel_time[47:0];
      pt.last = (i == n);
      expected_points.push_back(pt);
    end
  endtask

  // intake, prediction, result checking and the cycle cap
  always @(posedge clk) begin
    point_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (in_valid && !in_stall) predict_segment(pending_segs.pop_front());
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          $error("unexpected transaction: x %0d y %0d", out_pos_x, out_pos_y);
          mismatches++;
        end else begin
          e = expected_points.pop_front();
          if (out_pos_x !== e.pos_x) begin
            $error("pos_x: expected %0d, got %0d", e.pos_x, out_pos_x); mismatches++;
          end
          if (out_pos_y !== e.pos_y) begin
            $error("pos_y: expected %0d, got %0d", e.pos_y, out_pos_y); mismatches++;
          end
          if (out_speed !== e.speed) begin
            $error("speed: expected %0d, got %0d", e.speed, out_speed); mismatches++;
          end
          if (out_elapsed_time !== e.elapsed) begin
            $error("elapsed_time: expected %0d, got %0d", e.elapsed, out_elapsed_time);
            mismatches++;
          end
          if (out_last_of_segment !== e.last) begin
            $error("last_of_segment: expected %0b, got %0b", e.last, out_last_of_segment);
            mismatches++;
          end
        end
      end
    end
  end

  // driver: advance to the next segment once the current one has gone
  always @(negedge clk) begin
    if (!in_valid || in_fire) begin
      if (rst_n && pending_segs.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        in_valid    <= 1'b1;
        in_duration <= pending_segs[0].duration;
        in_coef_x0  <= pending_segs[0].cx0;
        in_coef_x1  <= pending_segs[0].cx1;
        in_coef_x2  <= pending_segs[0].cx2;
        in_coef_x3  <= pending_segs[0].cx3;
        in_coef_y0  <= pending_segs[0].cy0;
        in_coef_y1  <= pending_segs[0].cy1;
        in_coef_y2  <= pending_segs[0].cy2;
        in_coef_y3  <= pending_segs[0].cy3;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_off_seen != hold_off_count) begin
      hold_off_seen = hold_off_count;
      stall_left = HOLD_SPAN;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_SAMPLES:     samples_reg = val[5:0];
      CFG_SPEED_LIMIT: limit_reg = val;
      default:         gain_reg = val;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(logic [31:0] samples, logic [31:0] limit, logic [31:0] gain);
    write_reg(CFG_SAMPLES, samples);
    write_reg(CFG_SPEED_LIMIT, limit);
    write_reg(CFG_GAIN, gain);
  endtask

  task automatic drain();
    while (pending_segs.size() > 0 || in_valid || expected_points.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic push_seg(logic [31:0] dur, logic [31:0] x0, logic [31:0] x1,
                          logic [31:0] x2, logic [31:0] x3, logic [31:0] y0,
                          logic [31:0] y1, logic [31:0] y2, logic [31:0] y3);
    seg_t sg;
    sg = '{dur, x0, x1, x2, x3, y0, y1, y2, y3};
    pending_segs.push_back(sg);
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return $urandom;
      2:       return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
      default: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_duration();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return '0;
      default: return $urandom_range(1, 32'h0004_0000);
    endcase
  endfunction

  task automatic push_random(int count);
    repeat (count)
      push_seg(rand_duration(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
               rand_coef(), rand_coef(), rand_coef(), rand_coef());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // defaults: zero length, flat, extremes, a line, a curve, near-stationary start
    push_seg(0, 0, 0, 0, 0, 0, 0, 0, 0);
    push_seg(32'h0001_0000, 0, 0, 0, 0, 0, 0, 0, 0);
    push_seg(32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, 32'h0002_0000, 0, 0);
    push_seg(32'h0001_0000, 0, 32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000, 0);
    push_seg(32'h0001_0000, 0, 1, 32'h0003_0000, 32'hFFFF_0000, 0, 1, 32'h0001_0000, 0);
    push_seg(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_seg(32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    push_seg(32'h0000_8000, 32'hFFFF_0000, 32'h0000_0010, 0, 0, 32'h0001_0000, 0, 0, 0);
    drain();

    set_regs(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_seg(32'h0001_0000, 0, 32'h0001_0000, 32'h0000_4000, 0, 0, 0, 32'h0001_0000, 0);
    push_seg(32'hFFFF_FFFF, 0, 32'h0000_0100, 0, 0, 0, 0, 0, 0);
    push_seg(32'h0002_0000, 32'h1234_5678, 32'hFFFF_8000, 0, 32'h0000_0100,
             32'hEDCB_A988, 32'h0000_8000, 32'hFFFF_FF00, 0);
    drain();

    set_regs(63, 0, 0);
    push_seg(32'h0004_0000, 0, 32'h0001_0000, 0, 0, 0, 0, 32'h0002_0000, 0);
    push_seg(32'h0001_0000, 32'h0010_0000, 0, 0, 32'h0001_0000, 0, 32'h0001_0000, 0, 0);
    drain();

    // speed of one unit and large jumps drive the travel time into saturation
    set_regs(2, 1, 32'hFFFF_FFFF);
    repeat (4) begin
      push_seg(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0,
               32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
      push_seg(32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0,
               32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
    end
    drain();

    for (int mode = 0; mode < 3; mode++) begin
      sender_idle_pct   = (mode == 0) ? 27 : (mode == 1) ? 75 : 0;
      receiver_idle_pct = (mode == 0) ? 75 : (mode == 1) ? 27 : 0;
      for (int ph = 0; ph < 3; ph++) begin
        set_regs($urandom_range(1, 4),
                 ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 32'h0010_0000),
                 ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 32'h0010_0000));
        push_random(20);
        if (mode == 0 && ph == 0) hold_off_count++;
        drain();
      end
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/scs_pkg.sv
design/scs_front.sv
design/scs_arith.sv
design/scs_back.sv
design/spline_curvature_speed_sampler_unit.sv
design/scs_checker.sv
verif/testbench.sv
